[rtl/mexp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mexp_pkg;
    localparam int BASE_W = 63;
    localparam int MOD_W = 31;
    localparam int EXP_W_DEF = 32;
    localparam int PROD_W = 2 * MOD_W;
    localparam logic [0:0] REG_MODULUS = 1'b0;
    localparam logic [MOD_W-1:0] MOD_RESET = 31'd1;
endpackage
`default_nettype wire

[rtl/mexp_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// One bit of a restoring reduction chain: r = (2*r + bit) mod m, with r < m.
module mexp_cell
    import mexp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [MOD_W-1:0] m,
    input  wire logic [MOD_W-1:0] r_in,
    input  wire logic             bit_in,
    output logic      [MOD_W-1:0] r_out
);
    logic [MOD_W:0]   sh;
    logic [MOD_W-1:0] r_next;
    logic [MOD_W-1:0] r_reg;

    always_comb
    begin
        sh = {r_in, bit_in};
        if (sh >= {1'b0, m})
            r_next = MOD_W'(sh - {1'b0, m});
        else
            r_next = sh[MOD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            r_reg <= r_next;
    end

    assign r_out = r_reg;
endmodule
`default_nettype wire

[rtl/mexp_reduce.sv]
`timescale 1ns / 1ps
`default_nettype none
// Remainder of a wide value by m through a row of cells, one bit per cell.
// Bit W-1-k of the value feeds cell k; the last cell holds the remainder.
module mexp_reduce
    import mexp_pkg::*;
#(
    parameter int W = PROD_W
)
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [MOD_W-1:0] m,
    input  wire logic [W-1:0]     value,
    output logic      [MOD_W-1:0] rem
);
    logic [MOD_W-1:0] r [W+1];

    assign r[0] = '0;

    // Cell k holds the partial remainder after the top k+1 bits. Feeding all
    // cells from a held value makes the last cell exact once settled.
    for (genvar k = 0; k < W; k++)
    begin : g_cell
        mexp_cell u_cell (
            .clk    (clk),
            .en     (en),
            .m      (m),
            .r_in   (r[k]),
            .bit_in (value[W-1-k]),
            .r_out  (r[k+1])
        );
    end

    assign rem = r[W];
endmodule
`default_nettype wire

[rtl/modular_exponentiation.sv]
`timescale 1ns / 1ps
`default_nettype none
// Modular exponentiation, base^exponent mod modulus.
// Requests: base/exponent on a valid/ready input channel, power_mod on a
// valid/ready output channel. Modulus is written over the APB port
// (paddr 0 or 1); the user must write it only while idle, which the block
// does not enforce. Reset value 1, a zero modulus acts as 1.
// One request at a time. The base is reduced through a chain of 63 cells.
// Then each exponent bit, up to the top set one, runs a square and a
// multiply through two chains of 62 cells in parallel. The exponent is
// masked to its low EXP_BITS bits, at most 32.
// A zero exponent, or a base that reduces to zero, skips the bit loop.
// Reset clears all control; no request is held.
// The result waits in the output register while the receiver stalls; a new
// request is taken as soon as the result register is free.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = EXP_W_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [1:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BASE_W-1:0] base,
    input  wire logic [31:0]       exponent,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [MOD_W-1:0]  power_mod
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BASE = 2'd1;
    localparam logic [1:0] S_LOOP = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;
    localparam int CW = $clog2(BASE_W + 2);
    localparam int EW = (EXP_BITS > 32) ? 32 : EXP_BITS;

    logic [MOD_W-1:0]  modulus_reg;
    logic [MOD_W-1:0]  m_eff;
    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [BASE_W-1:0] base_reg;
    logic [31:0]       e_reg, e_next;
    logic [MOD_W-1:0]  b_reg, b_next, acc_reg, acc_next;
    logic [PROD_W-1:0] sq_reg, mu_reg, sq_next, mu_next;
    logic              out_valid_reg, out_valid_next;
    logic [MOD_W-1:0]  res_reg, res_next;
    logic [MOD_W-1:0]  base_rem, sq_rem, mu_rem;
    logic              en_base, en_loop, wr;
    logic [31:0]       e_mask;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite && (paddr[1] == 1'b0);
    assign prdata = {1'b0, modulus_reg};
    assign m_eff = (modulus_reg == '0) ? MOD_W'(1) : modulus_reg;

    always_comb
    begin
        e_mask = '0;
        for (int i = 0; i < EW; i++)
            e_mask[i] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MOD_RESET;
        else if (wr && (paddr[1:1] == REG_MODULUS))
            modulus_reg <= pwdata[MOD_W-1:0];
    end

    assign en_base = (state_reg == S_BASE);
    assign en_loop = (state_reg == S_LOOP);

    mexp_reduce #(.W(BASE_W)) u_base (
        .clk(clk), .en(en_base), .m(m_eff), .value(base_reg), .rem(base_rem));
    mexp_reduce #(.W(PROD_W)) u_sq (
        .clk(clk), .en(en_loop), .m(m_eff), .value(sq_reg), .rem(sq_rem));
    mexp_reduce #(.W(PROD_W)) u_mu (
        .clk(clk), .en(en_loop), .m(m_eff), .value(mu_reg), .rem(mu_rem));

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign power_mod = res_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        e_next = e_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        sq_next = sq_reg;
        mu_next = mu_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    e_next = exponent & e_mask;
                    cnt_next = '0;
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(BASE_W))
                begin
                    cnt_next = '0;
                    acc_next = MOD_W'(1);
                    b_next = base_rem;
                    if (e_reg == '0)
                    begin
                        res_next = MOD_W'(1);
                        state_next = S_DONE;
                    end
                    else if (base_rem == '0)
                    begin
                        res_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        sq_next = PROD_W'(base_rem) * PROD_W'(base_rem);
                        mu_next = PROD_W'(base_rem);
                        state_next = S_LOOP;
                    end
                end
            end
            S_LOOP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(PROD_W))
                begin
                    cnt_next = '0;
                    if (e_reg[0])
                        acc_next = mu_rem;
                    b_next = sq_rem;
                    e_next = e_reg >> 1;
                    if ((e_reg >> 1) == '0)
                    begin
                        res_next = e_reg[0] ? mu_rem : acc_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        sq_next = PROD_W'(sq_rem) * PROD_W'(sq_rem);
                        mu_next = PROD_W'(e_reg[0] ? mu_rem : acc_reg) * PROD_W'(sq_rem);
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            base_reg <= base;
        e_reg <= e_next;
        b_reg <= b_next;
        acc_reg <= acc_next;
        sq_reg <= sq_next;
        mu_reg <= mu_next;
        res_reg <= res_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_mod))
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_BASE)
        else $error("request not started");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> power_mod < m_eff || power_mod == MOD_W'(1))
        else $error("result not reduced");
endmodule
`default_nettype wire

[bench/modular_exponentiation_tb.sv]
`timescale 1ns / 1ps
module modular_exponentiation_tb;
    import mexp_pkg::*;

    localparam int EXP_BITS = EXP_W_DEF;
    localparam longint LIMIT = 12_000_000;
    localparam logic [1:0] ADDR_MODULUS = {REG_MODULUS, 1'b0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire [31:0] prdata;
    wire pready;
    logic in_valid = 1'b0;
    wire in_ready;
    logic [BASE_W-1:0] base = '0;
    logic [31:0] exponent = '0;
    wire out_valid;
    logic out_ready = 1'b0;
    wire [MOD_W-1:0] power_mod;

    modular_exponentiation #(.EXP_BITS(EXP_BITS)) u_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .base(base), .exponent(exponent),
        .out_valid(out_valid), .out_ready(out_ready), .power_mod(power_mod)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [MOD_W-1:0] modulus_q = MOD_RESET;
    logic [MOD_W-1:0] power_q[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_recv = 1'b0;
    longint cycles = 0;

    function automatic logic [MOD_W-1:0] mod_pow(logic [BASE_W-1:0] b_in,
                                                 logic [31:0] e_in);
        logic [63:0] m;
        logic [63:0] b;
        logic [63:0] acc;
        logic [63:0] e;
        m = {33'd0, modulus_q};
        if (m == 0)
            m = 1;
        b = {1'b0, b_in} % m;
        e = (EXP_BITS >= 32) ? {32'd0, e_in} : {32'd0, e_in & ((32'd1 << EXP_BITS) - 1)};
        acc = 1;
        if (e == 0)
            return MOD_W'(1);
        if (b == 0)
            return '0;
        while (e != 0)
        begin
            if (e[0])
                acc = (acc * b) % m;
            e = e >> 1;
            b = (b * b) % m;
        end
        return acc[MOD_W-1:0];
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL modular_exponentiation");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (power_q.size() == 0)
                begin
                    $display("%0t unexpected result %0d", $time, power_mod);
                    errors++;
                end
                else
                begin
                    if (power_mod !== power_q[0])
                    begin
                        $display("%0t power_mod mismatch: expected %0d actual %0d",
                                 $time, power_q[0], power_mod);
                        errors++;
                    end
                    void'(power_q.pop_front());
                end
                checked++;
            end
            out_ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(logic [BASE_W-1:0] b, logic [31:0] e);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        base <= b;
        exponent <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        power_q = {power_q, mod_pow(b, e)};
        sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (power_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_modulus(logic [31:0] value);
        wait_drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_MODULUS;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        modulus_q = value[MOD_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_exp();
        case ($urandom_range(5))
            0: return $urandom_range(15);
            1: return 32'd1 << $urandom_range(31);
            2: return $urandom;
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic logic [BASE_W-1:0] rand_base();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return v[BASE_W-1:0];
            1: return BASE_W'($urandom_range(7));
            2: return {32'd0, modulus_q} * $urandom_range(3);
            default: return v[BASE_W-1:0] >> $urandom_range(62);
        endcase
    endfunction

    task automatic test_reset_modulus();
        send_request('0, '0);
        send_request(63'd12345, 32'd7);
        send_request('1, '1);
    endtask

    task automatic test_directed();
        write_modulus(32'h7FFF_FFFF);
        send_request('0, 32'd0);
        send_request('0, 32'd5);
        send_request('1, 32'd0);
        send_request('1, '1);
        send_request(63'h7FFF_FFFF, 32'd3);
        send_request(63'd2, 32'd30);
        send_request(63'h7FFF_FFFE, '1);
        send_request(63'h5555_5555_5555_5555, 32'hAAAA_AAAA);
        send_request(63'h2AAA_AAAA_AAAA_AAAA, 32'h5555_5555);
        write_modulus(32'd1);
        send_request(63'd9, 32'd0);
        send_request(63'd9, 32'd4);
        write_modulus(32'd0);
        send_request(63'd9, 32'd0);
        send_request(63'd9, 32'd3);
        write_modulus(32'd2);
        send_request(63'd3, 32'd9);
        send_request(63'd4, 32'd9);
        write_modulus(32'd97);
        send_request(63'd97 * 5, 32'd11);
        send_request(63'd96, 32'h8000_0000);
    endtask

    task automatic test_random(int n, logic [31:0] m);
        write_modulus(m);
        repeat (n)
            send_request(rand_base(), rand_exp());
    endtask

    task automatic test_backpressure();
        int k;
        hold_recv = 1'b1;
        fork
            begin
                for (k = 0; k < 3000; k++)
                    @(posedge clk);
                hold_recv = 1'b0;
            end
            begin
                repeat (6)
                    send_request(rand_base(), $urandom_range(63));
                in_valid <= 1'b0;
            end
        join
        wait_drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_modulus();
        test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(290, 32'h7FFF_FFFF);
        send_idle_pct = 48;
        test_random(290, $urandom_range(32'h7FFF_FFFF, 2));
        send_idle_pct = 0;
        recv_stall_pct = 48;
        test_random(280, $urandom_range(1000, 2));
        send_idle_pct = 23;
        recv_stall_pct = 23;
        test_random(270, $urandom);
        test_backpressure();
        wait_drain();
        repeat (2200) @(posedge clk);
        $display("Sent %0d requests, checked %0d results over several moduli", sent, checked);
        $display("including idle, stall and long backpressure phases");
        if (errors == 0 && power_q.size() == 0)
            $display("PASS modular_exponentiation");
        else
            $display("FAIL modular_exponentiation");
        $finish;
    end
endmodule

[filelist.f]
rtl/mexp_pkg.sv
rtl/mexp_cell.sv
rtl/mexp_reduce.sv
rtl/modular_exponentiation.sv
bench/modular_exponentiation_tb.sv
